>>> hdl/rlsc_pkg.sv
// Shared types, codes and header layout for the replay log stream checker.
package rlsc_pkg;

	localparam int HEADER_BYTES  = 40;
	localparam int TRAILER_BYTES = 16;
	localparam int RECORD_BYTES  = 12;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	// result kinds
	localparam logic [1:0] KIND_IDENT   = 2'd0;
	localparam logic [1:0] KIND_FRAME   = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_VERDICT = 2'd3;

	// verdict reasons
	localparam logic [3:0] RSN_NONE     = 4'd0;
	localparam logic [3:0] RSN_SHORT    = 4'd1;
	localparam logic [3:0] RSN_MAGIC    = 4'd2;
	localparam logic [3:0] RSN_VERSION  = 4'd3;
	localparam logic [3:0] RSN_RESERVED = 4'd4;
	localparam logic [3:0] RSN_TICK     = 4'd5;
	localparam logic [3:0] RSN_LENGTH   = 4'd6;
	localparam logic [3:0] RSN_CUT      = 4'd7;
	localparam logic [3:0] RSN_COUNT    = 4'd8;
	localparam logic [3:0] RSN_HASH     = 4'd9;

	// parse phases
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_RECORD  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	// config register indexes
	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	// one request from the front to the back
	typedef struct packed {
		logic         body_v;
		logic [7:0]   body;
		logic         eof;
		logic [4:0]   fill;
		logic [127:0] trailer;
	} rlsc_item_t;

	// header segment that a header byte position falls in
	function automatic logic [2:0] seg_of(input logic [5:0] p);
		logic [2:0] s;
		if (p < 6'd4) s = 3'd0;
		else if (p < 6'd6) s = 3'd1;
		else if (p < 6'd8) s = 3'd2;
		else if (p < 6'd16) s = 3'd3;
		else if (p < 6'd20) s = 3'd4;
		else if (p < 6'd28) s = 3'd5;
		else if (p < 6'd32) s = 3'd6;
		else s = 3'd7;
		return s;
	endfunction

	function automatic logic [5:0] seg_start(input logic [2:0] s);
		logic [5:0] r;
		unique case (s)
			3'd0: r = 6'd0;
			3'd1: r = 6'd4;
			3'd2: r = 6'd6;
			3'd3: r = 6'd8;
			3'd4: r = 6'd16;
			3'd5: r = 6'd20;
			3'd6: r = 6'd28;
			default: r = 6'd32;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] seg_width(input logic [2:0] s);
		logic [3:0] r;
		unique case (s)
			3'd0, 3'd4, 3'd6: r = 4'd4;
			3'd1, 3'd2: r = 4'd2;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

	// one FNV-1a 64 step: (h ^ b) * 0x100000001b3
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x * 64'h1b3);
	endfunction

endpackage

>>> hdl/rlsc_front.sv
// Front: trailer delay window; once it is full, each accepted byte pushes out the oldest byte as a body request.
module rlsc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_file,
	output logic                  q_push,
	output rlsc_pkg::rlsc_item_t  q_item,
	input  logic                  q_ready
);
	import rlsc_pkg::*;

	logic [7:0] win_q [TRAILER_BYTES];
	logic [4:0] fill_q;
	logic       full;
	logic       acc;
	logic [4:0] fill_n;

	assign in_ready = q_ready;
	assign acc      = in_valid && q_ready;
	assign full     = (fill_q == 5'(TRAILER_BYTES));
	assign fill_n   = full ? fill_q : fill_q + 5'd1;

	// window shift line
	always_ff @(posedge clk) begin
		if (acc) begin
			if (full) begin
				for (int i = 0; i < TRAILER_BYTES - 1; i++) win_q[i] <= win_q[i + 1];
				win_q[TRAILER_BYTES - 1] <= data_byte;
			end else begin
				win_q[fill_q[3:0]] <= data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			fill_q <= end_of_file ? 5'd0 : fill_n;
		end
	end

	// request: oldest byte leaves as body, window copy rides along for the verdict
	always_comb begin
		q_item.body_v = full;
		q_item.body   = win_q[0];
		q_item.eof    = end_of_file;
		q_item.fill   = fill_n;
		for (int i = 0; i < TRAILER_BYTES; i++) begin
			if (full)
				q_item.trailer[8*i +: 8] = (i == TRAILER_BYTES - 1) ? data_byte : win_q[i + 1];
			else
				q_item.trailer[8*i +: 8] = (5'(i) == fill_q) ? data_byte : win_q[i];
		end
	end

	assign q_push = acc && (full || end_of_file);

endmodule

>>> hdl/rlsc_queue.sv
// Two-entry request queue between front and back.
module rlsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rlsc_pkg::rlsc_item_t  push_item,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  head_valid,
	output rlsc_pkg::rlsc_item_t  head_item
);
	import rlsc_pkg::*;

	rlsc_item_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hdl/rlsc_back.sv
// Back: hash, header and record parser, verdict, output register.
module rlsc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           magic_q,
	input  logic [15:0]           version_q,
	input  logic [31:0]           limit_q,
	input  logic                  head_valid,
	input  rlsc_pkg::rlsc_item_t  head_item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [2:0]            field_index,
	output logic [63:0]           value,
	output logic [31:0]           frame_length,
	output logic                  frame_end,
	output logic                  well_formed,
	output logic [3:0]            reason,
	output logic                  run_last
);
	import rlsc_pkg::*;

	// parser state
	logic [5:0]  hp_q, hp_n;
	logic [1:0]  ph_q, ph_n;
	logic [3:0]  rp_q, rp_n;
	logic [63:0] acc_q, acc_n;
	logic [31:0] len_q, len_n;
	logic [31:0] rem_q, rem_n;
	logic [63:0] frames_q, frames_n;
	logic [63:0] hash_q, hash_n;
	logic        err_q, err_n;
	logic [3:0]  why_q, why_n;
	logic        done_q, done_n;

	// result staging
	logic        go, emit, vdone;
	logic [1:0]  r_kind;
	logic [2:0]  r_idx;
	logic [63:0] r_val;
	logic [31:0] r_len;
	logic        r_fend, r_ok, r_last;
	logic [3:0]  r_why;

	// combinational temporaries
	logic [7:0]  b;
	logic [2:0]  s, k;
	logic [3:0]  w, rp;
	logic [63:0] base;
	logic [6:0]  total;
	logic [3:0]  vr;

	assign go = head_valid && (!out_valid || out_ready);

	always_comb begin
		hp_n = hp_q; ph_n = ph_q; rp_n = rp_q; acc_n = acc_q; len_n = len_q;
		rem_n = rem_q; frames_n = frames_q; hash_n = hash_q; err_n = err_q;
		why_n = why_q; done_n = done_q;
		emit = 1'b0; vdone = 1'b0; pop = 1'b0;
		r_kind = KIND_IDENT; r_idx = '0; r_val = '0; r_len = '0;
		r_fend = 1'b0; r_ok = 1'b0; r_why = RSN_NONE; r_last = 1'b0;
		b = head_item.body;
		s = seg_of(hp_q);
		k = 3'(hp_q - seg_start(s));
		w = seg_width(s);
		base = '0;
		rp = (rp_q >= 4'(RECORD_BYTES)) ? 4'd0 : rp_q;
		total = 7'(hp_q) + 7'(head_item.fill);
		vr = RSN_NONE;
		if (go && head_item.body_v && !done_q) begin
			// body byte step
			hash_n = fnv_step(hash_q, b);
			r_last = !head_item.eof;
			if (head_item.eof) done_n = 1'b1;
			else pop = 1'b1;
			if (hp_q < 6'(HEADER_BYTES)) begin
				hp_n = hp_q + 6'd1;
				if (!err_q) begin
					base = (k == 3'd0) ? 64'd0 : acc_q;
					acc_n = base | ({56'd0, b} << {k, 3'b000});
					if ({1'b0, k} + 4'd1 == w) begin
						priority if (s == 3'd0) begin
							if (acc_n[31:0] != magic_q) begin
								err_n = 1'b1; why_n = RSN_MAGIC;
							end
						end else if (s == 3'd1) begin
							if (acc_n[31:0] != {16'd0, version_q}) begin
								err_n = 1'b1; why_n = RSN_VERSION;
							end
						end else if (s == 3'd2) begin
							if (acc_n != 64'd0) begin
								err_n = 1'b1; why_n = RSN_RESERVED;
							end
						end else begin
							if (hp_q == 6'(HEADER_BYTES - 1)) ph_n = PH_RECORD;
							emit = 1'b1; r_kind = KIND_IDENT;
							r_idx = s - 3'd3; r_val = acc_n;
						end
					end
				end
			end else if (!err_q) begin
				if (ph_q == PH_PAYLOAD) begin
					rem_n = rem_q - 32'd1;
					emit = 1'b1; r_kind = KIND_PAYLOAD; r_val = {56'd0, b};
					r_fend = (rem_n == 32'd0);
					if (rem_n == 32'd0) begin
						frames_n = frames_q + 64'd1; ph_n = PH_RECORD;
					end
				end else begin
					// record byte: tick then length, little-endian
					if (rp < 4'd8) begin
						base = (rp == 4'd0) ? 64'd0 : acc_q;
						acc_n = base | ({56'd0, b} << {rp[2:0], 3'b000});
					end else begin
						len_n = ((rp == 4'd8) ? 32'd0 : len_q)
							| ({24'd0, b} << {rp[1:0], 3'b000});
					end
					if (rp + 4'd1 < 4'(RECORD_BYTES)) begin
						rp_n = rp + 4'd1;
					end else begin
						rp_n = 4'd0;
						if (acc_n != frames_q + 64'd1) begin
							err_n = 1'b1; why_n = RSN_TICK;
						end else if (len_n > limit_q) begin
							err_n = 1'b1; why_n = RSN_LENGTH;
						end else begin
							emit = 1'b1; r_kind = KIND_FRAME; r_val = acc_n;
							r_len = len_n; r_fend = (len_n == 32'd0);
							if (len_n == 32'd0) frames_n = frames_q + 64'd1;
							else begin
								rem_n = len_n; ph_n = PH_PAYLOAD;
							end
						end
					end
				end
			end
		end else if (go && head_item.eof) begin
			// verdict against the trailer
			priority if (hp_q < 6'(HEADER_BYTES) && total < 7'(HEADER_BYTES)) vr = RSN_SHORT;
			else if (err_q) vr = why_q;
			else if (hp_q < 6'(HEADER_BYTES) || head_item.fill < 5'(TRAILER_BYTES))
				vr = RSN_SHORT;
			else if (ph_q == PH_PAYLOAD || rp_q != 4'd0) vr = RSN_CUT;
			else if (head_item.trailer[63:0] != frames_q) vr = RSN_COUNT;
			else if (head_item.trailer[127:64] != hash_q) vr = RSN_HASH;
			else vr = RSN_NONE;
			emit = 1'b1; vdone = 1'b1; pop = 1'b1;
			r_kind = KIND_VERDICT; r_val = frames_q; r_ok = (vr == RSN_NONE);
			r_why = vr; r_last = 1'b1;
			hp_n = '0; ph_n = PH_HEADER; rp_n = '0; acc_n = '0; len_n = '0;
			rem_n = '0; frames_n = '0; hash_n = FNV_BASIS; err_n = 1'b0;
			why_n = RSN_NONE; done_n = 1'b0;
		end else if (go) begin
			pop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= '0; ph_q <= PH_HEADER; rp_q <= '0; acc_q <= '0; len_q <= '0;
			rem_q <= '0; frames_q <= '0; hash_q <= FNV_BASIS; err_q <= 1'b0;
			why_q <= RSN_NONE; done_q <= 1'b0;
		end else begin
			hp_q <= hp_n; ph_q <= ph_n; rp_q <= rp_n; acc_q <= acc_n; len_q <= len_n;
			rem_q <= rem_n; frames_q <= frames_n; hash_q <= hash_n; err_q <= err_n;
			why_q <= why_n; done_q <= done_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind <= r_kind; field_index <= r_idx; value <= r_val;
			frame_length <= r_len; frame_end <= r_fend; well_formed <= r_ok;
			reason <= r_why; run_last <= r_last;
		end
	end

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VERDICT |-> run_last)
		else $error("verdict without run_last");
	a_ok_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VERDICT && well_formed |-> reason == RSN_NONE)
		else $error("good verdict with a reason");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		vdone |=> frames_q == 64'd0 && hash_q == FNV_BASIS && !err_q)
		else $error("state not cleared after verdict");
	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_PAYLOAD |-> rem_q != 32'd0)
		else $error("payload phase with nothing left");

endmodule

>>> hdl/replay_log_stream_checker.sv
// Top level: config registers, front window, request queue and back parser.
// Each request is registered in the queue, then handled by the back parser into the
// output register; for a byte that carries both a body result and the verdict the
// body result comes first, then the verdict. Throughput: one byte per cycle while the
// output is not stalled, set by the one-step hash and parser in the back.
// Reset clears all control and parse state; registers return to their defaults.
module replay_log_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  field_index,
	output logic [63:0] value,
	output logic [31:0] frame_length,
	output logic        frame_end,
	output logic        well_formed,
	output logic [3:0]  reason,
	output logic        run_last
);
	import rlsc_pkg::*;

	logic [31:0] magic_q;
	logic [15:0] version_q;
	logic [31:0] limit_q;
	logic        q_push, q_ready, q_pop, h_valid;
	rlsc_item_t  q_item, h_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 32'd0;
			version_q <= 16'd1;
			limit_q   <= 32'd65536;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data;
				REG_VERSION: version_q <= cfg_data[15:0];
				REG_LIMIT:   limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	rlsc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .end_of_file,
		.q_push, .q_item, .q_ready
	);

	rlsc_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_item(q_item), .push_ready(q_ready),
		.pop(q_pop), .head_valid(h_valid), .head_item(h_item)
	);

	rlsc_back u_back (
		.clk, .arst_n, .magic_q, .version_q, .limit_q,
		.head_valid(h_valid), .head_item(h_item), .pop(q_pop),
		.out_valid, .out_ready, .kind, .field_index, .value, .frame_length,
		.frame_end, .well_formed, .reason, .run_last
	);

endmodule
